// ===== rtl/core/pqc_pkg.sv =====
package pqc_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int BUCKET_BITS_DEF     = 5;
  localparam int COLOR_W             = 8;
  localparam int IDX_W               = 8;
  localparam int CACHE_W             = IDX_W + 1;
  localparam int RGB_W               = 3 * COLOR_W;
  localparam int SQ_W                = 2 * COLOR_W;
  localparam int DIST_W              = SQ_W + 2;

  typedef enum logic [1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_PAL_WRITE = 2'd1,
    KIND_FRAME     = 2'd2,
    KIND_RSVD      = 2'd3
  } kind_t;

  typedef enum logic {
    RT_PIXEL = 1'b0,
    RT_FRAME = 1'b1
  } result_type_t;

  typedef enum logic [1:0] {
    RES_HIT,
    RES_SEARCH,
    RES_FS_KEEP,
    RES_FS_RELOAD
  } res_sel_t;

  typedef enum logic [3:0] {
    S_CLEAR_ALL,
    S_IDLE,
    S_WR_CMP,
    S_PX_CHECK,
    S_SEARCH,
    S_DRAIN,
    S_PX_STORE,
    S_FS_CHECK,
    S_CLEAR_CACHE,
    S_COPY,
    S_COPY_TAIL,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic     idle;
    logic     clear_step;
    logic     clear_pal;
    logic     rebuild_start;
    logic     copy_step;
    logic     wr_commit;
    logic     search_start;
    logic     search_step;
    logic     px_store;
    logic     res_load;
    res_sel_t res_sel;
    logic     emit;
  } pqc_cmd_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] kind;
    logic       clear_last;
    logic       changed;
    logic       copy_last;
    logic       hit;
    logic       search_last;
    logic       pipe_busy;
    logic       out_free;
  } pqc_stat_t;

endpackage

// ===== rtl/core/pqc_if.sv =====
interface pqc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] entry;

  modport source (output valid, kind, red, green, blue, entry, input ready);
  modport sink (input valid, kind, red, green, blue, entry, output ready);
endinterface

interface pqc_result_if;
  logic       valid;
  logic       ready;
  logic       result_type;
  logic [7:0] pixel_index;
  logic       palette_reloaded;

  modport source (output valid, result_type, pixel_index, palette_reloaded, input ready);
  modport sink (input valid, result_type, pixel_index, palette_reloaded, output ready);
endinterface

// ===== rtl/core/palette_quantizer_with_bucket_cache.sv =====
// Maps RGB pixels to palette indices through a bucket cache of nearest-color results.
// The item channel carries pixels, palette entry writes and frame starts; the result
// channel returns one word per pixel and per frame start, nothing for palette writes.
// After reset the block runs a clearing pass over all 2^(3*BUCKET_BITS_PER_CHANNEL) cache
// buckets (32768 by default) and both palettes and accepts no item meanwhile.
// One item is worked on at a time. A pixel that hits its bucket takes its result from
// the check state; a miss scans the whole active palette once through the single read
// port of the palette memory and stores the nearest entry in its bucket.
// A palette write updates the shadow palette when its entry is in range. A frame start
// with no palette change answers without a rebuild; a rebuild clears the cache one
// bucket per cycle and then copies and seeds one palette entry per cycle.
// A finished result waits in the output register while the receiver stalls; the block
// takes the next item meanwhile and holds only when a second result is ready.
module palette_quantizer_with_bucket_cache
  import pqc_pkg::*;
#(
  parameter int PALETTE_ENTRIES         = PALETTE_ENTRIES_DEF,
  parameter int BUCKET_BITS_PER_CHANNEL = BUCKET_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pqc_item_if.sink     item,
  pqc_result_if.source result
);

  pqc_cmd_t  cmd;
  pqc_stat_t st;

  pqc_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  pqc_dp #(
    .PALETTE_ENTRIES         (PALETTE_ENTRIES),
    .BUCKET_BITS_PER_CHANNEL (BUCKET_BITS_PER_CHANNEL)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cmd    (cmd),
    .st     (st)
  );

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && st.out_free |=> result.valid)
    else $error("result word not presented after emit");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready &&
    (item.kind == KIND_PIXEL || item.kind == KIND_PAL_WRITE || item.kind == KIND_FRAME)
    |=> !item.ready)
    else $error("block accepted a second word while busy");

  a_reload_on_frame: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.palette_reloaded |-> result.result_type == RT_FRAME)
    else $error("reload flag on a pixel result");

endmodule

// ===== rtl/core/pqc_ram.sv =====
module pqc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/pqc_ctrl.sv =====
module pqc_ctrl
  import pqc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  pqc_stat_t st,
  output pqc_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR_ALL;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR_ALL: if (st.clear_last) state_next = S_IDLE;
      S_IDLE: begin
        if (st.accept) begin
          unique case (st.kind)
            KIND_PIXEL:     state_next = S_PX_CHECK;
            KIND_PAL_WRITE: state_next = S_WR_CMP;
            KIND_FRAME:     state_next = S_FS_CHECK;
            default:        state_next = S_IDLE;
          endcase
        end
      end
      S_WR_CMP:      state_next = S_IDLE;
      S_PX_CHECK:    state_next = st.hit ? S_EMIT : S_SEARCH;
      S_SEARCH:      if (st.search_last) state_next = S_DRAIN;
      S_DRAIN:       if (!st.pipe_busy) state_next = S_PX_STORE;
      S_PX_STORE:    state_next = S_EMIT;
      S_FS_CHECK:    state_next = st.changed ? S_CLEAR_CACHE : S_EMIT;
      S_CLEAR_CACHE: if (st.clear_last) state_next = S_COPY;
      S_COPY:        if (st.copy_last) state_next = S_COPY_TAIL;
      S_COPY_TAIL:   state_next = S_EMIT;
      S_EMIT:        if (st.out_free) state_next = S_IDLE;
      default:       state_next = S_CLEAR_ALL;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.res_sel = RES_HIT;
    unique case (state)
      S_CLEAR_ALL: begin
        cmd.clear_step = 1'b1;
        cmd.clear_pal  = 1'b1;
      end
      S_IDLE:   cmd.idle = 1'b1;
      S_WR_CMP: cmd.wr_commit = 1'b1;
      S_PX_CHECK: begin
        cmd.res_load     = st.hit;
        cmd.res_sel      = RES_HIT;
        cmd.search_start = !st.hit;
      end
      S_SEARCH: cmd.search_step = 1'b1;
      S_DRAIN:  cmd = '0;
      S_PX_STORE: begin
        cmd.px_store = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_SEARCH;
      end
      S_FS_CHECK: begin
        cmd.rebuild_start = st.changed;
        cmd.res_load      = !st.changed;
        cmd.res_sel       = RES_FS_KEEP;
      end
      S_CLEAR_CACHE: cmd.clear_step = 1'b1;
      S_COPY:        cmd.copy_step = 1'b1;
      S_COPY_TAIL: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_FS_RELOAD;
      end
      S_EMIT:  cmd.emit = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/pqc_dp.sv =====
module pqc_dp
  import pqc_pkg::*;
#(
  parameter int PALETTE_ENTRIES         = PALETTE_ENTRIES_DEF,
  parameter int BUCKET_BITS_PER_CHANNEL = BUCKET_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pqc_item_if.sink     item,
  pqc_result_if.source result,
  input  pqc_cmd_t     cmd,
  output pqc_stat_t    st
);

  localparam int BB      = BUCKET_BITS_PER_CHANNEL;
  localparam int KEY_W   = 3 * BB;
  localparam int BUCKETS = 1 << KEY_W;
  localparam int PIDX_W  = $clog2(PALETTE_ENTRIES);
  localparam int CNT_W   = $clog2(PALETTE_ENTRIES + 1);

  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic [IDX_W-1:0]   entry;
  logic [RGB_W-1:0]   color;
  logic               ent_ok;

  logic [KEY_W-1:0]  sweep;
  logic [PIDX_W-1:0] pal_cnt;
  logic              sweep_low;

  logic [CNT_W-1:0]           differs_cnt;
  logic                       table_valid;
  logic                       old_diff;
  logic                       new_diff;

  logic              copy_v;
  logic [PIDX_W-1:0] copy_idx;

  logic              s0_v;
  logic [PIDX_W-1:0] s0_idx;
  logic              s1_v;
  logic [PIDX_W-1:0] s1_idx;
  logic [SQ_W-1:0]   sq_r;
  logic [SQ_W-1:0]   sq_g;
  logic [SQ_W-1:0]   sq_b;
  logic [DIST_W-1:0] cand_d;
  logic [DIST_W:0]   best_d;
  logic [PIDX_W-1:0] best;
  logic [COLOR_W-1:0] dr;
  logic [COLOR_W-1:0] dg;
  logic [COLOR_W-1:0] db;

  logic               res_type;
  logic [IDX_W-1:0]   res_idx;
  logic               res_reloaded;
  logic               out_v;
  logic               out_type;
  logic [IDX_W-1:0]   out_idx;
  logic               out_reloaded;

  logic               cache_we;
  logic [KEY_W-1:0]   cache_waddr;
  logic [CACHE_W-1:0] cache_wdata;
  logic [KEY_W-1:0]   cache_raddr;
  logic [CACHE_W-1:0] cache_rdata;

  logic              shadow_we;
  logic [PIDX_W-1:0] shadow_waddr;
  logic [RGB_W-1:0]  shadow_wdata;
  logic [PIDX_W-1:0] shadow_raddr;
  logic [RGB_W-1:0]  shadow_rdata;

  logic              active_we;
  logic [PIDX_W-1:0] active_waddr;
  logic [RGB_W-1:0]  active_wdata;
  logic [PIDX_W-1:0] active_raddr;
  logic [RGB_W-1:0]  active_rdata;

  logic [KEY_W-1:0]  seed_key;

  always_ff @(posedge clk) begin
    if (item.valid && cmd.idle) begin
      red   <= item.red;
      green <= item.green;
      blue  <= item.blue;
      entry <= item.entry;
    end
  end

  assign color     = {red, green, blue};
  assign ent_ok    = {1'b0, entry} < (IDX_W + 1)'(PALETTE_ENTRIES);
  assign sweep_low = sweep < KEY_W'(PALETTE_ENTRIES);
  assign old_diff  = shadow_rdata != active_rdata;
  assign new_diff  = color != active_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep       <= '0;
      differs_cnt <= '0;
      table_valid <= 1'b0;
      copy_v      <= 1'b0;
      s0_v        <= 1'b0;
      s1_v        <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        sweep <= sweep + 1'b1;
      end
      if (cmd.rebuild_start) begin
        differs_cnt <= '0;
        table_valid <= 1'b1;
      end else if (cmd.wr_commit && ent_ok) begin
        if (old_diff && !new_diff) begin
          differs_cnt <= differs_cnt - 1'b1;
        end else if (!old_diff && new_diff) begin
          differs_cnt <= differs_cnt + 1'b1;
        end
      end
      copy_v <= cmd.copy_step;
      s0_v   <= cmd.search_step;
      s1_v   <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rebuild_start) begin
      pal_cnt <= PIDX_W'(PALETTE_ENTRIES - 1);
    end else if (cmd.search_start) begin
      pal_cnt <= '0;
    end else if (cmd.copy_step) begin
      pal_cnt <= pal_cnt - 1'b1;
    end else if (cmd.search_step) begin
      pal_cnt <= pal_cnt + 1'b1;
    end
    copy_idx <= pal_cnt;
    s0_idx   <= pal_cnt;
  end

  assign dr = (active_rdata[RGB_W-1 -: COLOR_W] > red)
            ? active_rdata[RGB_W-1 -: COLOR_W] - red
            : red - active_rdata[RGB_W-1 -: COLOR_W];
  assign dg = (active_rdata[SQ_W-1 -: COLOR_W] > green)
            ? active_rdata[SQ_W-1 -: COLOR_W] - green
            : green - active_rdata[SQ_W-1 -: COLOR_W];
  assign db = (active_rdata[COLOR_W-1:0] > blue)
            ? active_rdata[COLOR_W-1:0] - blue
            : blue - active_rdata[COLOR_W-1:0];

  always_ff @(posedge clk) begin
    sq_r   <= dr * dr;
    sq_g   <= dg * dg;
    sq_b   <= db * db;
    s1_idx <= s0_idx;
  end

  assign cand_d = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

  always_ff @(posedge clk) begin
    if (cmd.search_start) begin
      best   <= '0;
      best_d <= '1;
    end else if (s1_v && ({1'b0, cand_d} < best_d)) begin
      best   <= s1_idx;
      best_d <= {1'b0, cand_d};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_sel)
        RES_HIT: begin
          res_type     <= RT_PIXEL;
          res_idx      <= cache_rdata[IDX_W-1:0];
          res_reloaded <= 1'b0;
        end
        RES_SEARCH: begin
          res_type     <= RT_PIXEL;
          res_idx      <= IDX_W'(best);
          res_reloaded <= 1'b0;
        end
        RES_FS_KEEP: begin
          res_type     <= RT_FRAME;
          res_idx      <= '0;
          res_reloaded <= 1'b0;
        end
        RES_FS_RELOAD: begin
          res_type     <= RT_FRAME;
          res_idx      <= '0;
          res_reloaded <= 1'b1;
        end
        default: begin
          res_type     <= RT_PIXEL;
          res_idx      <= '0;
          res_reloaded <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (cmd.emit && st.out_free) begin
      out_v <= 1'b1;
    end else if (result.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && st.out_free) begin
      out_type     <= res_type;
      out_idx      <= res_idx;
      out_reloaded <= res_reloaded;
    end
  end

  assign result.valid            = out_v;
  assign result.result_type      = out_type;
  assign result.pixel_index      = out_idx;
  assign result.palette_reloaded = out_reloaded;
  assign item.ready              = cmd.idle;

  assign seed_key    = {shadow_rdata[RGB_W-1 -: BB], shadow_rdata[SQ_W-1 -: BB],
                        shadow_rdata[COLOR_W-1 -: BB]};
  assign cache_raddr = {item.red[COLOR_W-1 -: BB], item.green[COLOR_W-1 -: BB],
                        item.blue[COLOR_W-1 -: BB]};

  always_comb begin
    cache_we    = 1'b0;
    cache_waddr = sweep;
    cache_wdata = '0;
    priority if (cmd.clear_step) begin
      cache_we = 1'b1;
    end else if (copy_v) begin
      cache_we    = 1'b1;
      cache_waddr = seed_key;
      cache_wdata = {1'b1, IDX_W'(copy_idx)};
    end else if (cmd.px_store) begin
      cache_we    = 1'b1;
      cache_waddr = {red[COLOR_W-1 -: BB], green[COLOR_W-1 -: BB], blue[COLOR_W-1 -: BB]};
      cache_wdata = {1'b1, IDX_W'(best)};
    end
  end

  always_comb begin
    shadow_we    = 1'b0;
    shadow_waddr = sweep[PIDX_W-1:0];
    shadow_wdata = '0;
    active_we    = 1'b0;
    active_waddr = sweep[PIDX_W-1:0];
    active_wdata = '0;
    priority if (cmd.clear_step) begin
      shadow_we = cmd.clear_pal && sweep_low;
      active_we = cmd.clear_pal && sweep_low;
    end else if (copy_v) begin
      active_we    = 1'b1;
      active_waddr = copy_idx;
      active_wdata = shadow_rdata;
    end else if (cmd.wr_commit) begin
      shadow_we    = ent_ok;
      shadow_waddr = entry[PIDX_W-1:0];
      shadow_wdata = color;
    end
  end

  assign active_raddr = cmd.idle ? item.entry[PIDX_W-1:0] : pal_cnt;
  assign shadow_raddr = cmd.idle ? item.entry[PIDX_W-1:0] : pal_cnt;

  pqc_ram #(
    .WIDTH (CACHE_W),
    .DEPTH (BUCKETS)
  ) u_cache (
    .clk   (clk),
    .we    (cache_we),
    .waddr (cache_waddr),
    .wdata (cache_wdata),
    .raddr (cache_raddr),
    .rdata (cache_rdata)
  );

  pqc_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_shadow (
    .clk   (clk),
    .we    (shadow_we),
    .waddr (shadow_waddr),
    .wdata (shadow_wdata),
    .raddr (shadow_raddr),
    .rdata (shadow_rdata)
  );

  pqc_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_active (
    .clk   (clk),
    .we    (active_we),
    .waddr (active_waddr),
    .wdata (active_wdata),
    .raddr (active_raddr),
    .rdata (active_rdata)
  );

  assign st.accept      = item.valid && cmd.idle;
  assign st.kind        = item.kind;
  assign st.clear_last  = sweep == KEY_W'(BUCKETS - 1);
  assign st.changed     = !table_valid || (differs_cnt != '0);
  assign st.copy_last   = pal_cnt == '0;
  assign st.hit         = cache_rdata[CACHE_W-1];
  assign st.search_last = pal_cnt == PIDX_W'(PALETTE_ENTRIES - 1);
  assign st.pipe_busy   = s0_v || s1_v;
  assign st.out_free    = !out_v || result.ready;

endmodule
